// ----- design/assert_macros.svh -----
// assertion macros used by the top level of the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every rising edge outside reset
`define VSA_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// checked on every rising edge, reset included
`define VSA_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define VSA_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define VSA_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ----- design/vsa_pkg.sv -----
// types, codes and defaults of the voice slot allocator
package vsa_pkg;

	localparam int NUM_SLOTS_DEF   = 32;
	localparam int FIRST_FX_DEF    = 1;
	localparam int INDEX_BITS_DEF  = 8;
	localparam int BACKGROUND_SLOT = 0;
	localparam int SLOT_W_MAX      = 8;

	// command codes
	localparam logic [2:0] CMD_PLAY_FX  = 3'd0;
	localparam logic [2:0] CMD_PLAY_BG  = 3'd1;
	localparam logic [2:0] CMD_STOP_H   = 3'd2;
	localparam logic [2:0] CMD_STOP_BG  = 3'd3;
	localparam logic [2:0] CMD_STOP_ALL = 3'd4;
	localparam logic [2:0] CMD_QUERY    = 3'd5;
	localparam logic [2:0] CMD_FINISHED = 3'd6;

	// action codes
	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_START    = 2'd1;
	localparam logic [1:0] ACT_STOP     = 2'd2;
	localparam logic [1:0] ACT_STOP_ALL = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] handle;
		logic [9:0]  sound_id;
		logic        loop;
		logic [4:0]  voice_slot;
	} item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  slot;
		logic [31:0] new_handle;
		logic [9:0]  start_sound;
		logic        start_loop;
		logic        top_priority;
		logic        replaced;
		logic        handle_valid;
		logic        playing;
	} result_t;

	// outcome of the round-robin search
	typedef struct packed {
		logic                  found;
		logic [SLOT_W_MAX-1:0] slot;
	} pick_t;

endpackage

// ----- design/vsa_gen_mem.sv -----
// generation memory, registered read, per-entry valid bits
module vsa_gen_mem #(
	parameter int DEPTH     = vsa_pkg::NUM_SLOTS_DEF,
	parameter int ADDR_BITS = 5,
	parameter int DATA_BITS = 32 - vsa_pkg::INDEX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data
);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [DATA_BITS-1:0] rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// entry never written reads as generation zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ----- design/vsa_search.sv -----
// round-robin search for a free effect slot, registered result
module vsa_search #(
	parameter int NUM_SLOTS         = vsa_pkg::NUM_SLOTS_DEF,
	parameter int FIRST_EFFECT_SLOT = vsa_pkg::FIRST_FX_DEF,
	parameter int SLOT_BITS         = 5
) (
	input  logic                 clk,
	input  logic [NUM_SLOTS-1:0] assigned,
	input  logic [NUM_SLOTS-1:0] active,
	input  logic [SLOT_BITS-1:0] cursor,
	output vsa_pkg::pick_t       pick_s1
);

	logic [NUM_SLOTS-1:0] free_v;
	logic [NUM_SLOTS-1:0] ahead_v;
	logic [SLOT_BITS-1:0] ahead_idx;
	logic [SLOT_BITS-1:0] any_idx;
	vsa_pkg::pick_t       pick_d;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			free_v[i]  = (i >= FIRST_EFFECT_SLOT) && !(assigned[i] && active[i]);
			ahead_v[i] = free_v[i] && (SLOT_BITS'(i) >= cursor);
		end
	end

	// lowest set bit of each vector
	always_comb begin
		ahead_idx = '0;
		any_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (ahead_v[i]) begin
				ahead_idx = SLOT_BITS'(i);
			end
			if (free_v[i]) begin
				any_idx = SLOT_BITS'(i);
			end
		end
	end

	// first free slot at or after the cursor, else wrap to the lowest free effect slot, else evict at the cursor
	always_comb begin
		pick_d.found = |free_v;
		if (|ahead_v) begin
			pick_d.slot = vsa_pkg::SLOT_W_MAX'(ahead_idx);
		end else if (|free_v) begin
			pick_d.slot = vsa_pkg::SLOT_W_MAX'(any_idx);
		end else begin
			pick_d.slot = vsa_pkg::SLOT_W_MAX'(cursor);
		end
	end

	always_ff @(posedge clk) begin
		pick_s1 <= pick_d;
	end

endmodule

// ----- design/voice_slot_allocator_generational.sv -----
// top level of the voice slot allocator with generational handles
// sequence: an accepted transaction runs the search, the generation memory read and the
// write-back in turn, then raises its result strobe, held for one cycle; a new transaction
// may start in that cycle, and none is taken while busy
// reset: all slots unassigned and idle, generations zero, cursor on first effect slot
module voice_slot_allocator_generational #(
	parameter int NUM_SLOTS         = vsa_pkg::NUM_SLOTS_DEF,
	parameter int FIRST_EFFECT_SLOT = vsa_pkg::FIRST_FX_DEF,
	parameter int INDEX_BITS        = vsa_pkg::INDEX_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  vsa_pkg::item_t   item,
	output logic             done,
	output vsa_pkg::result_t result
);

	`include "assert_macros.svh"

	localparam int  SLOT_BITS = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
	localparam int  GEN_BITS  = 32 - INDEX_BITS;
	localparam bit  HAS_FX    = FIRST_EFFECT_SLOT < NUM_SLOTS;
	localparam logic [GEN_BITS-1:0] GEN_MAX = '1;
	localparam logic [SLOT_BITS-1:0] BG_SLOT = SLOT_BITS'(vsa_pkg::BACKGROUND_SLOT);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SRCH = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]             state_q;
	vsa_pkg::item_t         item_q;
	logic [NUM_SLOTS-1:0]   asg_q, asg_d;
	logic [NUM_SLOTS-1:0]   act_q, act_d;
	logic [SLOT_BITS-1:0]   cursor_q, cursor_d;
	vsa_pkg::pick_t         pick_s1;
	logic [SLOT_BITS-1:0]   fx_slot;
	logic [SLOT_BITS-1:0]   mem_addr;
	logic [GEN_BITS-1:0]    gen_old;
	logic [GEN_BITS-1:0]    gen_new;
	logic                   gen_we;
	logic [31:0]            hidx32;
	logic [SLOT_BITS-1:0]   hslot;
	logic                   h_range;
	logic                   h_asg;
	logic                   h_act;
	logic                   h_ok;
	logic                   vs_hit;
	vsa_pkg::result_t       res_d;
	vsa_pkg::result_t       result_q;
	logic                   done_q;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// sequencer: search, memory read, write-back and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: state_q <= ST_READ;
				ST_READ: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command held for the whole transaction
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
	end

	// slot flags sit still while a transaction runs, so the search sees settled state
	vsa_search #(
		.NUM_SLOTS         (NUM_SLOTS),
		.FIRST_EFFECT_SLOT (FIRST_EFFECT_SLOT),
		.SLOT_BITS         (SLOT_BITS)
	) u_search (
		.clk      (clk),
		.assigned (asg_q),
		.active   (act_q),
		.cursor   (cursor_q),
		.pick_s1  (pick_s1)
	);

	assign fx_slot = pick_s1.slot[SLOT_BITS-1:0];

	// handle decode: slot in the low bits, generation above
	assign hidx32  = 32'(item_q.handle[INDEX_BITS-1:0]);
	assign hslot   = hidx32[SLOT_BITS-1:0];
	assign h_range = (hidx32 >= 32'(FIRST_EFFECT_SLOT)) && (hidx32 < 32'(NUM_SLOTS));

	always_comb begin
		h_asg  = 1'b0;
		h_act  = 1'b0;
		vs_hit = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (hslot == SLOT_BITS'(i)) begin
				h_asg = asg_q[i];
				h_act = act_q[i];
			end
			if (32'(item_q.voice_slot) == 32'(i)) begin
				vs_hit = 1'b1;
			end
		end
	end

	// read address stays put through read and write-back, so the same entry is written
	always_comb begin
		unique case (item_q.command)
			vsa_pkg::CMD_PLAY_FX: mem_addr = fx_slot;
			vsa_pkg::CMD_PLAY_BG: mem_addr = BG_SLOT;
			default:              mem_addr = hslot;
		endcase
	end

	vsa_gen_mem #(
		.DEPTH     (NUM_SLOTS),
		.ADDR_BITS (SLOT_BITS),
		.DATA_BITS (GEN_BITS)
	) u_gen_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (mem_addr),
		.rd_data (gen_old),
		.wr_en   (gen_we),
		.wr_addr (mem_addr),
		.wr_data (gen_new)
	);

	// generation wraps from its maximum to one, so zero never names a live voice
	assign gen_new = (gen_old == GEN_MAX) ? GEN_BITS'(1) : gen_old + 1'b1;
	assign h_ok    = (item_q.handle != '0) && h_range && (item_q.handle[31:INDEX_BITS] == gen_old)
		&& h_asg;

	// write-back and result for the command in hand
	always_comb begin
		res_d    = '0;
		asg_d    = asg_q;
		act_d    = act_q;
		cursor_d = cursor_q;
		gen_we   = 1'b0;
		unique case (item_q.command)
			vsa_pkg::CMD_PLAY_FX: begin
				res_d.start_sound = item_q.sound_id;
				res_d.start_loop  = item_q.loop;
				if (HAS_FX) begin
					gen_we           = (state_q == ST_DONE);
					asg_d[fx_slot]   = 1'b1;
					act_d[fx_slot]   = 1'b1;
					res_d.action     = vsa_pkg::ACT_START;
					res_d.slot       = 5'(fx_slot);
					res_d.new_handle = {gen_new, {INDEX_BITS{1'b0}}} | 32'(fx_slot);
					// no free slot: the voice at the cursor is cut off
					res_d.replaced   = !pick_s1.found;
					cursor_d         = (fx_slot == SLOT_BITS'(NUM_SLOTS - 1))
						? SLOT_BITS'(FIRST_EFFECT_SLOT) : fx_slot + 1'b1;
				end
			end
			vsa_pkg::CMD_PLAY_BG: begin
				gen_we             = (state_q == ST_DONE);
				asg_d[BG_SLOT]     = 1'b1;
				act_d[BG_SLOT]     = 1'b1;
				res_d.action       = vsa_pkg::ACT_START;
				res_d.slot         = 5'(BG_SLOT);
				res_d.new_handle   = {gen_new, {INDEX_BITS{1'b0}}} | 32'(BG_SLOT);
				res_d.replaced     = asg_q[BG_SLOT] && act_q[BG_SLOT];
				res_d.start_sound  = item_q.sound_id;
				res_d.start_loop   = 1'b1;
				res_d.top_priority = 1'b1;
			end
			vsa_pkg::CMD_STOP_H: begin
				if (h_ok) begin
					asg_d[hslot]       = 1'b0;
					act_d[hslot]       = 1'b0;
					res_d.action       = vsa_pkg::ACT_STOP;
					res_d.slot         = hidx32[4:0];
					res_d.handle_valid = 1'b1;
				end
			end
			vsa_pkg::CMD_STOP_BG: begin
				if (asg_q[BG_SLOT]) begin
					asg_d[BG_SLOT] = 1'b0;
					act_d[BG_SLOT] = 1'b0;
					res_d.action   = vsa_pkg::ACT_STOP;
					res_d.slot     = 5'(BG_SLOT);
				end
			end
			vsa_pkg::CMD_STOP_ALL: begin
				asg_d        = '0;
				act_d        = '0;
				res_d.action = vsa_pkg::ACT_STOP_ALL;
			end
			vsa_pkg::CMD_QUERY: begin
				res_d.handle_valid = h_ok;
				res_d.playing      = h_ok && h_act;
			end
			vsa_pkg::CMD_FINISHED: begin
				// finished voice stays assigned, only stops counting as playing
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (vs_hit && (32'(item_q.voice_slot) == 32'(i))) begin
						act_d[i] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asg_q    <= '0;
			act_q    <= '0;
			cursor_q <= SLOT_BITS'(FIRST_EFFECT_SLOT);
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
			if (state_q == ST_DONE) begin
				asg_q    <= asg_d;
				act_q    <= act_d;
				cursor_q <= cursor_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			result_q <= res_d;
		end
	end

	`VSA_ASSERT(a_done_after_wb, clk, arst_n, done |-> $past(state_q) == ST_DONE, "strobe without write-back")
	`VSA_ASSERT(a_done_single, clk, arst_n, done |=> !done, "strobe longer than one cycle")
	`VSA_ASSERT(a_accept_starts, clk, arst_n, (start && !busy) |=> (state_q == ST_SRCH), "accepted transaction not started")
	`VSA_ASSERT(a_cursor_range, clk, arst_n, !HAS_FX || ((32'(cursor_q) >= 32'(FIRST_EFFECT_SLOT)) && (32'(cursor_q) < 32'(NUM_SLOTS))), "cursor outside effect slots")
	`VSA_ASSERT_ALWAYS(a_active_assigned, clk, !arst_n || ((act_q & ~asg_q) == '0), "playing slot not assigned")

endmodule
